>>> src/dsa_pkg.sv
// ============================================================================
// dsa_pkg
// Widths, reset values, register indexes and shared types of the damped
// spring animator.
// ============================================================================
`default_nettype none

package dsa_pkg;

    // Field widths.
    localparam int DATA_W    = 32;
    localparam int DT_W      = 16;
    localparam int DT_FRAC   = 16;
    localparam int EPS_W     = 31;
    localparam int CFG_IDX_W = 4;

    // Datapath widths of the update.
    localparam int MAG_W   = DATA_W + 1;        // |position - goal|
    localparam int PROD_W  = DATA_W + MAG_W;    // coefficient times magnitude
    localparam int SUM_W   = PROD_W + 2;        // signed sum of both products
    localparam int NUM_W   = SUM_W - 1;         // magnitude of that sum
    localparam int QUOT_W  = 48;                // quotient bits below the cap
    localparam int HI_W    = NUM_W - QUOT_W;    // dividend bits above the quotient
    localparam int ACC_W   = QUOT_W + 1;        // acceleration magnitude
    localparam int MT_W    = ACC_W + DT_W;      // product with the time step

    // Register reset values.
    localparam logic [DATA_W-1:0] STIFFNESS_RST = 32'h00AA_0000;
    localparam logic [DATA_W-1:0] DAMPING_RST   = 32'h001A_0000;
    localparam logic [DATA_W-1:0] MASS_RST      = 32'h0001_0000;
    localparam logic [EPS_W-1:0]  EPSILON_RST   = 31'd66;

    // Saturation limits.
    localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STIFFNESS = 4'd0,
        REG_DAMPING   = 4'd1,
        REG_MASS      = 4'd2,
        REG_EPSILON   = 4'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [DATA_W-1:0] stiffness;
        logic [DATA_W-1:0] damping_coeff;
        logic [DATA_W-1:0] mass;
        logic [EPS_W-1:0]  epsilon;
    } cfg_t;

    typedef struct packed {
        logic [DATA_W-1:0] position;
        logic [DATA_W-1:0] speed;
        logic              settled;
    } res_t;

endpackage

`default_nettype wire

>>> src/dsa_mul.sv
// ============================================================================
// dsa_mul
// Bit-serial unsigned shift-and-add multiplier: one multiplier bit per
// cycle.
// ============================================================================
`default_nettype none

module dsa_mul #(
    parameter int WA = dsa_pkg::DATA_W,
    parameter int WB = dsa_pkg::MAG_W
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          start_i,
    input  wire logic [WA-1:0] a_i,
    input  wire logic [WB-1:0] b_i,
    output logic               done_o,
    output logic [WA+WB-1:0]   prod_o
);

    localparam int CNT_W = $clog2(WB + 1);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic [WA-1:0]    a_reg;
    logic [WA-1:0]    hi_reg;
    logic [WB-1:0]    lo_reg;
    logic [WA:0]      sum;

    assign sum = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, a_reg} : {(WA+1){1'b0}});

    always_comb begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start_i) begin
            cnt_next = CNT_W'(WB);
        end else if (cnt_reg != '0) begin
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    // The partial sum moves in from the top while the multiplier bits leave
    // at the bottom.
    always_ff @(posedge aclk) begin
        if (start_i) begin
            a_reg  <= a_i;
            hi_reg <= '0;
            lo_reg <= b_i;
        end else if (cnt_reg != '0) begin
            hi_reg <= sum[WA:1];
            lo_reg <= {sum[0], lo_reg[WB-1:1]};
        end
    end

    assign done_o = done_reg;
    assign prod_o = {hi_reg, lo_reg};

endmodule

`default_nettype wire

>>> src/dsa_div.sv
// ============================================================================
// dsa_div
// Restoring radix-2 divider: one quotient bit per cycle. The
// starting remainder must be below the divisor.
// ============================================================================
`default_nettype none

module dsa_div #(
    parameter int WQ = dsa_pkg::QUOT_W,
    parameter int WD = dsa_pkg::DATA_W
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          start_i,
    input  wire logic [WD-1:0] rem_i,
    input  wire logic [WQ-1:0] num_i,
    input  wire logic [WD-1:0] den_i,
    output logic               done_o,
    output logic [WQ-1:0]      quot_o
);

    localparam int CNT_W = $clog2(WQ + 1);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic [WD-1:0]    rem_reg;
    logic [WQ-1:0]    num_reg;
    logic [WD-1:0]    den_reg;
    logic [WD:0]      trial;
    logic [WD:0]      diff;

    assign trial = {rem_reg, num_reg[WQ-1]};
    assign diff  = trial - {1'b0, den_reg};

    always_comb begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start_i) begin
            cnt_next = CNT_W'(WQ);
        end else if (cnt_reg != '0) begin
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    // Dividend bits leave at the top of num_reg while quotient bits enter
    // at the bottom.
    always_ff @(posedge aclk) begin
        if (start_i) begin
            rem_reg <= rem_i;
            num_reg <= num_i;
            den_reg <= den_i;
        end else if (cnt_reg != '0) begin
            rem_reg <= diff[WD] ? trial[WD-1:0] : diff[WD-1:0];
            num_reg <= {num_reg[WQ-2:0], ~diff[WD]};
        end
    end

    assign done_o = done_reg;
    assign quot_o = num_reg;

endmodule

`default_nettype wire

>>> src/dsa_core.sv
// ============================================================================
// dsa_core
// Sequencer and state of the spring: goal, position and velocity, with the
// serial multipliers and the divider that carry out one Euler step.
// ============================================================================
`default_nettype none

module dsa_core (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           start_i,
    input  wire logic [dsa_pkg::DATA_W-1:0]     target_i,
    input  wire logic [dsa_pkg::DT_W-1:0]       dt_i,
    input  wire logic                           jump_i,
    input  wire dsa_pkg::cfg_t                  cfg_i,
    output logic                                idle_o,
    output logic                                res_valid_o,
    input  wire logic                           res_ready_i,
    output dsa_pkg::res_t                       res_o
);

    localparam int DW  = dsa_pkg::DATA_W;
    localparam int VSW = dsa_pkg::ACC_W + 2;   // velocity update with sign room
    localparam int PSW = DW + 2;               // position update with sign room

    typedef enum logic [11:0] {
        ST_IDLE   = 12'b0000_0000_0001,
        ST_CHECK  = 12'b0000_0000_0010,
        ST_MULKC  = 12'b0000_0000_0100,
        ST_SUM    = 12'b0000_0000_1000,
        ST_ABS    = 12'b0000_0001_0000,
        ST_DIVCHK = 12'b0000_0010_0000,
        ST_DIV    = 12'b0000_0100_0000,
        ST_VSTART = 12'b0000_1000_0000,
        ST_VWAIT  = 12'b0001_0000_0000,
        ST_XSTART = 12'b0010_0000_0000,
        ST_XWAIT  = 12'b0100_0000_0000,
        ST_FINISH = 12'b1000_0000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [DW-1:0]                  pos_reg, pos_next;
    logic [DW-1:0]                  vel_reg, vel_next;
    logic [DW-1:0]                  goal_reg, goal_next;
    logic [dsa_pkg::DT_W-1:0]       dt_reg;
    logic                           jump_reg;
    logic [dsa_pkg::SUM_W-1:0]      t_reg;
    logic [dsa_pkg::NUM_W-1:0]      mag_reg;
    logic                           neg_reg;
    logic [dsa_pkg::ACC_W-1:0]      amag_reg, amag_next;

    logic [dsa_pkg::MAG_W-1:0]      delta;
    logic [dsa_pkg::MAG_W-1:0]      dist_mag;
    logic [DW-1:0]                  vel_mag;
    logic                           settled_now;

    logic                           kc_start;
    logic                           k_done, c_done;
    logic [dsa_pkg::PROD_W-1:0]     k_prod, c_prod;
    logic [dsa_pkg::SUM_W-1:0]      k_term, c_term, t_next;

    logic [DW-1:0]                  den;
    logic [DW-1:0]                  mag_hi;
    logic                           acc_cap;
    logic                           div_start, div_done;
    logic [dsa_pkg::QUOT_W-1:0]     div_quot;

    logic                           mt_start, mt_done;
    logic [dsa_pkg::ACC_W-1:0]      mt_a;
    logic [dsa_pkg::MT_W-1:0]       mt_prod;

    logic [dsa_pkg::ACC_W-1:0]      dv;
    logic [VSW-1:0]                 dv_ext, v_sum;
    logic                           v_ovf;
    logic [DW-1:0]                  dx;
    logic [PSW-1:0]                 dx_ext, p_sum;
    logic                           p_ovf;

    // Distance to the goal and speed magnitudes, used by the settle test and
    // as multiplier operands.
    assign delta    = {pos_reg[DW-1], pos_reg} - {goal_reg[DW-1], goal_reg};
    assign dist_mag = delta[dsa_pkg::MAG_W-1] ? (dsa_pkg::MAG_W'(0) - delta) : delta;
    assign vel_mag  = vel_reg[DW-1] ? (DW'(0) - vel_reg) : vel_reg;
    assign settled_now = (dist_mag < {2'b00, cfg_i.epsilon}) &&
                         (vel_mag < {1'b0, cfg_i.epsilon});

    // Both spring products run side by side, over the distance and speed bits.
    assign kc_start = (state_reg == ST_CHECK) && !(jump_reg || settled_now);

    dsa_mul #(
        .WA (DW),
        .WB (dsa_pkg::MAG_W)
    ) u_mul_k (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start_i (kc_start),
        .a_i     (cfg_i.stiffness),
        .b_i     (dist_mag),
        .done_o  (k_done),
        .prod_o  (k_prod)
    );

    dsa_mul #(
        .WA (DW),
        .WB (dsa_pkg::MAG_W)
    ) u_mul_c (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start_i (kc_start),
        .a_i     (cfg_i.damping_coeff),
        .b_i     ({1'b0, vel_mag}),
        .done_o  (c_done),
        .prod_o  (c_prod)
    );

    // Signed sum stiffness*d + damping*v; each conditional negation is an
    // inversion plus a carry in.
    assign k_term = {2'b00, k_prod} ^ {dsa_pkg::SUM_W{delta[dsa_pkg::MAG_W-1]}};
    assign c_term = {2'b00, c_prod} ^ {dsa_pkg::SUM_W{vel_reg[DW-1]}};
    assign t_next = k_term + c_term + dsa_pkg::SUM_W'(delta[dsa_pkg::MAG_W-1])
                  + dsa_pkg::SUM_W'(vel_reg[DW-1]);

    // A zero mass counts as one LSB. The quotient reaches the cap exactly
    // when the dividend bits above the quotient field are not below the mass.
    assign den     = (cfg_i.mass == '0) ? DW'(1) : cfg_i.mass;
    assign mag_hi  = {{(DW-dsa_pkg::HI_W){1'b0}},
                      mag_reg[dsa_pkg::NUM_W-1:dsa_pkg::QUOT_W]};
    assign acc_cap = (mag_hi >= den);
    assign div_start = (state_reg == ST_DIVCHK) && !acc_cap;

    dsa_div #(
        .WQ (dsa_pkg::QUOT_W),
        .WD (DW)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start_i (div_start),
        .rem_i   (mag_hi),
        .num_i   (mag_reg[dsa_pkg::QUOT_W-1:0]),
        .den_i   (den),
        .done_o  (div_done),
        .quot_o  (div_quot)
    );

    // One multiplier by the time step serves both the velocity and the
    // position update.
    assign mt_start = (state_reg == ST_VSTART) || (state_reg == ST_XSTART);
    assign mt_a     = (state_reg == ST_XSTART) ?
                      {{(dsa_pkg::ACC_W-DW){1'b0}}, vel_mag} : amag_reg;

    dsa_mul #(
        .WA (dsa_pkg::ACC_W),
        .WB (dsa_pkg::DT_W)
    ) u_mul_t (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start_i (mt_start),
        .a_i     (mt_a),
        .b_i     (dt_reg),
        .done_o  (mt_done),
        .prod_o  (mt_prod)
    );

    assign dv     = mt_prod[dsa_pkg::DT_FRAC +: dsa_pkg::ACC_W];
    assign dv_ext = {2'b00, dv};
    assign v_sum  = {{(VSW-DW){vel_reg[DW-1]}}, vel_reg}
                  + (neg_reg ? (VSW'(0) - dv_ext) : dv_ext);
    assign v_ovf  = !((&v_sum[VSW-1:DW-1]) || !(|v_sum[VSW-1:DW-1]));

    assign dx     = mt_prod[dsa_pkg::DT_FRAC +: DW];
    assign dx_ext = {2'b00, dx};
    assign p_sum  = {{(PSW-DW){pos_reg[DW-1]}}, pos_reg}
                  + (vel_reg[DW-1] ? (PSW'(0) - dx_ext) : dx_ext);
    assign p_ovf  = !((&p_sum[PSW-1:DW-1]) || !(|p_sum[PSW-1:DW-1]));

    always_comb begin
        state_next = state_reg;
        pos_next   = pos_reg;
        vel_next   = vel_reg;
        goal_next  = goal_reg;
        amag_next  = amag_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (start_i) begin
                    goal_next  = target_i;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (jump_reg || settled_now) begin
                    pos_next   = goal_reg;
                    vel_next   = '0;
                    state_next = ST_FINISH;
                end else begin
                    state_next = ST_MULKC;
                end
            end
            ST_MULKC: begin
                if (k_done && c_done) begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM: begin
                state_next = ST_ABS;
            end
            ST_ABS: begin
                state_next = ST_DIVCHK;
            end
            ST_DIVCHK: begin
                if (acc_cap) begin
                    amag_next  = {1'b1, {dsa_pkg::QUOT_W{1'b0}}};
                    state_next = ST_VSTART;
                end else begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    amag_next  = {1'b0, div_quot};
                    state_next = ST_VSTART;
                end
            end
            ST_VSTART: begin
                state_next = ST_VWAIT;
            end
            ST_VWAIT: begin
                if (mt_done) begin
                    vel_next   = v_ovf ? (v_sum[VSW-1] ? dsa_pkg::SAT_MIN : dsa_pkg::SAT_MAX)
                                       : v_sum[DW-1:0];
                    state_next = ST_XSTART;
                end
            end
            ST_XSTART: begin
                state_next = ST_XWAIT;
            end
            ST_XWAIT: begin
                if (mt_done) begin
                    pos_next   = p_ovf ? (p_sum[PSW-1] ? dsa_pkg::SAT_MIN : dsa_pkg::SAT_MAX)
                                       : p_sum[DW-1:0];
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (res_ready_i) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pos_reg   <= '0;
            vel_reg   <= '0;
            goal_reg  <= '0;
        end else begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            vel_reg   <= vel_next;
            goal_reg  <= goal_next;
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == ST_IDLE) && start_i) begin
            dt_reg   <= dt_i;
            jump_reg <= jump_i;
        end
        if (state_reg == ST_SUM) begin
            t_reg <= t_next;
        end
        // The force is the negated sum, so the acceleration is negative when
        // the sum is positive.
        if (state_reg == ST_ABS) begin
            mag_reg <= t_reg[dsa_pkg::SUM_W-1] ?
                       dsa_pkg::NUM_W'(dsa_pkg::SUM_W'(0) - t_reg) :
                       t_reg[dsa_pkg::NUM_W-1:0];
            neg_reg <= !t_reg[dsa_pkg::SUM_W-1] && (t_reg != '0);
        end
        amag_reg <= amag_next;
    end

    assign idle_o           = (state_reg == ST_IDLE);
    assign res_valid_o      = (state_reg == ST_FINISH);
    assign res_o.position   = pos_reg;
    assign res_o.speed      = vel_reg;
    assign res_o.settled    = settled_now;

endmodule

`default_nettype wire

>>> src/damped_spring_animator.sv
// ============================================================================
// damped_spring_animator
// Damped spring that moves a signed Q16.16 value toward a target, one
// semi-implicit Euler step per integrating item, with value and velocity saturating.
// ============================================================================
// Usage:
//   The s_ channel takes one item (new_target, time_step, jump) per step; the
//   m_ channel returns one item per input with position, speed and settled.
//   The cfg_ channel writes stiffness, damping_coeff, mass and epsilon by
//   index; it is always ready and indexes past the list are ignored. Write
//   it only while no item is in flight.
//   An item with jump set, or one that finds the spring already settled,
//   snaps to the goal at rest. An integrating item runs through the serial
//   datapath: a shift-add multiplier pair, a restoring divider by mass,
//   which is skipped when the acceleration hits its cap, and two
//   multiplies by the time step.
//   The result goes to an output register, so the next item is accepted
//   while a finished result waits. When the receiver stalls and that
//   register is still full, the sequencer holds its result and s_ready
//   stays low.
//   Reset (synchronous, active low) clears position, velocity and goal to
//   zero and loads the default register values.
// ============================================================================
`default_nettype none

module damped_spring_animator (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic signed [dsa_pkg::DATA_W-1:0]  s_new_target,
    input  wire logic [dsa_pkg::DT_W-1:0]           s_time_step,
    input  wire logic                               s_jump,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic signed [dsa_pkg::DATA_W-1:0]       m_position,
    output logic signed [dsa_pkg::DATA_W-1:0]       m_speed,
    output logic                                    m_settled,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [dsa_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [dsa_pkg::DATA_W-1:0]         cfg_data
);

    dsa_pkg::cfg_t cfg_reg, cfg_next;
    dsa_pkg::res_t core_res;
    dsa_pkg::res_t out_reg;
    logic          m_valid_reg, m_valid_next;
    logic          core_idle;
    logic          core_res_valid;
    logic          res_ready;
    logic          in_accept;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (dsa_pkg::cfg_idx_t'(cfg_index))
                dsa_pkg::REG_STIFFNESS: cfg_next.stiffness     = cfg_data;
                dsa_pkg::REG_DAMPING:   cfg_next.damping_coeff = cfg_data;
                dsa_pkg::REG_MASS:      cfg_next.mass          = cfg_data;
                dsa_pkg::REG_EPSILON:   cfg_next.epsilon       = cfg_data[dsa_pkg::EPS_W-1:0];
                default: ;
            endcase
        end
    end

    assign s_ready   = core_idle;
    assign in_accept = s_valid && s_ready;

    dsa_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start_i     (in_accept),
        .target_i    (s_new_target),
        .dt_i        (s_time_step),
        .jump_i      (s_jump),
        .cfg_i       (cfg_reg),
        .idle_o      (core_idle),
        .res_valid_o (core_res_valid),
        .res_ready_i (res_ready),
        .res_o       (core_res)
    );

    // The output register takes a new result when it is empty or is being
    // emptied in the same cycle.
    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (core_res_valid && res_ready) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg       <= 1'b0;
            cfg_reg.stiffness     <= dsa_pkg::STIFFNESS_RST;
            cfg_reg.damping_coeff <= dsa_pkg::DAMPING_RST;
            cfg_reg.mass          <= dsa_pkg::MASS_RST;
            cfg_reg.epsilon       <= dsa_pkg::EPSILON_RST;
        end else begin
            m_valid_reg <= m_valid_next;
            cfg_reg     <= cfg_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (core_res_valid && res_ready) begin
            out_reg <= core_res;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_position = out_reg.position;
    assign m_speed    = out_reg.speed;
    assign m_settled  = out_reg.settled;

endmodule

`default_nettype wire

>>> src/dsa_checker.sv
// ============================================================================
// dsa_checker
// Port-level checks of the damped spring animator, bound to the top level.
// ============================================================================
`default_nettype none

module dsa_checker (
    input wire logic                               aclk,
    input wire logic                               aresetn,
    input wire logic                               s_valid,
    input wire logic                               s_ready,
    input wire logic signed [dsa_pkg::DATA_W-1:0]  s_new_target,
    input wire logic                               s_jump,
    input wire logic                               m_valid,
    input wire logic                               m_ready,
    input wire logic signed [dsa_pkg::DATA_W-1:0]  m_position,
    input wire logic signed [dsa_pkg::DATA_W-1:0]  m_speed,
    input wire logic                               m_settled
);

    // No result is pending right after reset.
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // The block works on one item at a time.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second item accepted while busy");

    // A jump into an empty output register shows the target at rest.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_jump && !m_valid |->
        ##3 (m_valid && (m_position == $past(s_new_target, 3)) && (m_speed == '0)))
        else $error("jump result wrong or late");

    // A stalled result holds.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_position) && $stable(m_speed)
        && $stable(m_settled))
        else $error("stalled result changed");

endmodule

bind damped_spring_animator dsa_checker u_dsa_checker (.*);

`default_nettype wire

>>> tb/tb_damped_spring_animator.sv
// ============================================================================
// tb_damped_spring_animator
// Self-checking bench for the damped spring animator. A scoreboard object
// keeps its own copy of the spring state and registers, predicts position,
// speed and settled for every accepted input item, and compares each output
// item with the oldest prediction. Directed corner items come first, then
// random target sequences under several register settings and idle patterns.
// ============================================================================
`default_nettype none

module tb_damped_spring_animator;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 800;
    localparam int END_PAD        = 130;
    localparam logic [dsa_pkg::DT_W-1:0] FRAME_60HZ = 16'd1092;

    // Index outside the register list; the block must ignore it.
    localparam logic [dsa_pkg::CFG_IDX_W-1:0] REG_NONE = 4'hF;

    class spring_scoreboard;
        logic [dsa_pkg::DATA_W-1:0]        stiff;
        logic [dsa_pkg::DATA_W-1:0]        damp;
        logic [dsa_pkg::DATA_W-1:0]        mass_q;
        logic [dsa_pkg::EPS_W-1:0]         eps;
        logic signed [dsa_pkg::DATA_W-1:0] pos;
        logic signed [dsa_pkg::DATA_W-1:0] vel;
        logic signed [dsa_pkg::DATA_W-1:0] goal;
        dsa_pkg::res_t                     expected_states[$];
        int                                failures;
        int                                checked;

        function new();
            stiff    = dsa_pkg::STIFFNESS_RST;
            damp     = dsa_pkg::DAMPING_RST;
            mass_q   = dsa_pkg::MASS_RST;
            eps      = dsa_pkg::EPSILON_RST;
            pos      = '0;
            vel      = '0;
            goal     = '0;
            failures = 0;
            checked  = 0;
        endfunction

        function void write_reg(logic [dsa_pkg::CFG_IDX_W-1:0] idx,
                                logic [dsa_pkg::DATA_W-1:0] data);
            case (idx)
                dsa_pkg::REG_STIFFNESS: stiff  = data;
                dsa_pkg::REG_DAMPING:   damp   = data;
                dsa_pkg::REG_MASS:      mass_q = data;
                dsa_pkg::REG_EPSILON:   eps    = data[dsa_pkg::EPS_W-1:0];
                default: ;
            endcase
        endfunction

        function logic signed [dsa_pkg::DATA_W-1:0] clamp32(longint v);
            if (v > 64'sd2147483647)
                return dsa_pkg::SAT_MAX;
            if (v < -64'sd2147483648)
                return dsa_pkg::SAT_MIN;
            return v[31:0];
        endfunction

        function bit is_settled();
            longint d;
            longint dmag;
            longint vmag;
            d    = longint'(pos) - longint'(goal);
            dmag = (d < 0) ? -d : d;
            vmag = (vel < 0) ? -longint'(vel) : longint'(vel);
            return (dmag < longint'(eps)) && (vmag < longint'(eps));
        endfunction

        // One semi-implicit Euler step: velocity first, then position.
        function void step_spring(logic [dsa_pkg::DT_W-1:0] dt);
            logic signed [127:0] dist_w;
            logic signed [127:0] velw;
            logic signed [127:0] force_sum;
            logic [127:0]        num;
            logic [127:0]        divisor;
            logic [127:0]        quo;
            logic [127:0]        dv;
            longint              dl;
            longint              vnew;
            longint              dx;
            longint              pnew;
            bit                  neg;
            dl        = longint'(pos) - longint'(goal);
            dist_w    = {{64{dl[63]}}, dl};
            velw      = {{96{vel[31]}}, vel};
            force_sum = -($signed({96'd0, stiff}) * dist_w + $signed({96'd0, damp}) * velw);
            neg       = force_sum[127];
            num       = neg ? -force_sum : force_sum;
            divisor   = (mass_q == '0) ? 128'd1 : {96'd0, mass_q};
            quo       = num / divisor;
            // The acceleration magnitude is capped at 2^48.
            if (quo >= (128'd1 << 48))
                quo = 128'd1 << 48;
            dv   = (quo * dt) >> 16;
            vnew = longint'(vel) + (neg ? -longint'(dv[63:0]) : longint'(dv[63:0]));
            vel  = clamp32(vnew);
            dx   = (((vel < 0) ? -longint'(vel) : longint'(vel)) * longint'(dt)) >> 16;
            pnew = longint'(pos) + ((vel < 0) ? -dx : dx);
            pos  = clamp32(pnew);
        endfunction

        function void note_item(logic [dsa_pkg::DATA_W-1:0] target,
                                logic [dsa_pkg::DT_W-1:0] dt, logic jump);
            dsa_pkg::res_t r;
            goal = target;
            if (jump || is_settled()) begin
                pos = goal;
                vel = '0;
            end else begin
                step_spring(dt);
            end
            r.position = pos;
            r.speed    = vel;
            r.settled  = is_settled();
            expected_states = {expected_states, r};
        endfunction

        function void check_item(logic [dsa_pkg::DATA_W-1:0] p,
                                 logic [dsa_pkg::DATA_W-1:0] s, logic st);
            dsa_pkg::res_t e;
            if (expected_states.size() == 0) begin
                if (failures < 10)
                    $display("unexpected output item: position %h speed %h settled %b",
                             p, s, st);
                failures++;
                return;
            end
            e = expected_states.pop_front();
            if (p !== e.position || s !== e.speed || st !== e.settled) begin
                if (failures < 10)
                    $display("item %0d: position exp %h got %h, speed exp %h got %h, %s%b %s%b",
                             checked, e.position, p, e.speed, s,
                             "settled exp ", e.settled, "got ", st);
                failures++;
            end
            checked++;
        endfunction

        function int pending();
            return expected_states.size();
        endfunction
    endclass

    logic                               aclk;
    logic                               aresetn;
    logic                               s_valid;
    logic                               s_ready;
    logic signed [dsa_pkg::DATA_W-1:0]  s_new_target;
    logic [dsa_pkg::DT_W-1:0]           s_time_step;
    logic                               s_jump;
    logic                               m_valid;
    logic                               m_ready;
    logic signed [dsa_pkg::DATA_W-1:0]  m_position;
    logic signed [dsa_pkg::DATA_W-1:0]  m_speed;
    logic                               m_settled;
    logic                               cfg_valid;
    logic                               cfg_ready;
    logic [dsa_pkg::CFG_IDX_W-1:0]      cfg_index;
    logic [dsa_pkg::DATA_W-1:0]         cfg_data;

    spring_scoreboard sb;
    int               src_idle_pct;
    int               snk_idle_pct;
    int               hold_request;
    int               quiet_cycles;

    damped_spring_animator i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_new_target (s_new_target),
        .s_time_step  (s_time_step),
        .s_jump       (s_jump),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_position   (m_position),
        .m_speed      (m_speed),
        .m_settled    (m_settled),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Receiver: random back-pressure, plus one long hold-off on request.
    initial begin : receiver
        int held;
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_request != 0) begin
                m_ready <= 1'b0;
                for (held = 0; held < hold_request; held++)
                    @(posedge aclk);
                hold_request = 0;
            end
            m_ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // Monitor and watchdog. Values are sampled before the edge's updates land.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_index, cfg_data);
            if (s_valid && s_ready)
                sb.note_item(s_new_target, s_time_step, s_jump);
            if (m_valid && m_ready)
                sb.check_item(m_position, m_speed, m_settled);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    function automatic logic [dsa_pkg::DATA_W-1:0] pick_target();
        case ($urandom_range(9))
            0:       return dsa_pkg::SAT_MAX;
            1:       return dsa_pkg::SAT_MIN;
            2, 3, 4: return $urandom;
            // Half the picks: targets within +-32.0, where the spring behaves normally.
            default: return $urandom_range(32'h0040_0000) - 32'h0020_0000;
        endcase
    endfunction

    function automatic logic [dsa_pkg::DT_W-1:0] pick_dt();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2, 3:    return dsa_pkg::DT_W'($urandom);
            4, 5, 6: return FRAME_60HZ;
            default: return dsa_pkg::DT_W'($urandom_range(500, 4400));
        endcase
    endfunction

    // The caller's step is either the acceptance edge or a fresh one, so
    // s_valid gets only one assignment per step.
    task automatic send_item(logic [dsa_pkg::DATA_W-1:0] target,
                             logic [dsa_pkg::DT_W-1:0] dt, logic jump);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_new_target <= target;
        s_time_step  <= dt;
        s_jump       <= jump;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0)
            @(posedge aclk);
    endtask

    task automatic write_reg(logic [dsa_pkg::CFG_IDX_W-1:0] idx,
                             logic [dsa_pkg::DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic program_spring(logic [dsa_pkg::DATA_W-1:0] k,
                                  logic [dsa_pkg::DATA_W-1:0] c,
                                  logic [dsa_pkg::DATA_W-1:0] m,
                                  logic [dsa_pkg::DATA_W-1:0] e);
        drain();
        write_reg(dsa_pkg::REG_STIFFNESS, k);
        write_reg(dsa_pkg::REG_DAMPING, c);
        write_reg(dsa_pkg::REG_MASS, m);
        write_reg(dsa_pkg::REG_EPSILON, e);
        write_reg(REG_NONE, $urandom);
        cfg_valid <= 1'b0;
    endtask

    // Random part: the spring chases one target for a while, with occasional
    // jumps, changes of frame time and unrelated noise items in between.
    task automatic run_random(int count);
        int                         sent;
        int                         span;
        logic [dsa_pkg::DATA_W-1:0] tgt;
        logic [dsa_pkg::DT_W-1:0]   dt;
        sent = 0;
        while (sent < count) begin
            tgt  = pick_target();
            dt   = pick_dt();
            span = $urandom_range(1, 40);
            for (int k = 0; k < span && sent < count; k++) begin
                if ($urandom_range(19) == 0)
                    send_item($urandom, dsa_pkg::DT_W'($urandom), 1'($urandom_range(1)));
                else
                    send_item(tgt, ($urandom_range(9) == 0) ? pick_dt() : dt,
                              (k == 0 && $urandom_range(3) == 0) || $urandom_range(29) == 0);
                sent++;
            end
        end
    endtask

    initial begin : stimulus
        s_valid      = 1'b0;
        s_new_target = '0;
        s_time_step  = '0;
        s_jump       = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        aresetn      = 1'b0;
        quiet_cycles = 0;
        hold_request = 0;
        src_idle_pct = 9;
        snk_idle_pct = 68;
        sb = new();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset register values.
        send_item(dsa_pkg::SAT_MAX, 16'hFFFF, 1'b1);
        send_item(dsa_pkg::SAT_MAX, FRAME_60HZ, 1'b0);  // at rest on the goal: snaps
        send_item(dsa_pkg::SAT_MIN, 16'hFFFF, 1'b0);    // full-scale pull saturates
        send_item(dsa_pkg::SAT_MIN, 16'hFFFF, 1'b0);
        send_item(dsa_pkg::SAT_MAX, 16'hFFFF, 1'b0);
        send_item(dsa_pkg::SAT_MIN, 16'd0, 1'b1);
        send_item(32'd0, 16'd0, 1'b0);            // zero time step: nothing moves
        send_item(32'd0, 16'd0, 1'b1);
        send_item(32'd40, FRAME_60HZ, 1'b0);      // inside epsilon: snaps
        send_item(32'd106, FRAME_60HZ, 1'b0);     // exactly epsilon away: integrates
        repeat (4) send_item(32'h0001_0000, FRAME_60HZ, 1'b0);
        send_item(-32'sd5, 16'd1, 1'b1);
        send_item(-32'sd70, 16'hFFFF, 1'b0);
        run_random(240);

        // Strongest spring, zero mass and zero epsilon.
        program_spring('1, '1, '0, '0);
        send_item(32'd100, 16'd1000, 1'b1);       // no settling without epsilon
        send_item(32'd100, 16'd1000, 1'b0);
        send_item(dsa_pkg::SAT_MAX, 16'd1, 1'b0); // acceleration hits its cap
        send_item(dsa_pkg::SAT_MIN, 16'd0, 1'b0);
        send_item(dsa_pkg::SAT_MIN, 16'hFFFF, 1'b0);
        run_random(60);

        src_idle_pct = 68;
        snk_idle_pct = 9;
        // No spring force, largest mass and epsilon.
        program_spring('0, '0, '1, '1);
        run_random(60);
        repeat (2) begin
            program_spring($urandom_range(1, 2000) << 16, $urandom_range(0, 120) << 16,
                           $urandom_range(32'h0000_1000, 32'h0008_0000),
                           $urandom_range(0, 20000));
            run_random(100);
        end

        src_idle_pct = 0;
        snk_idle_pct = 0;
        program_spring(dsa_pkg::STIFFNESS_RST, dsa_pkg::DAMPING_RST, dsa_pkg::MASS_RST,
                       {1'b0, dsa_pkg::EPSILON_RST});
        hold_request = HOLD_CYCLES;
        run_random(200);
        program_spring($urandom, $urandom, $urandom, $urandom);
        run_random(190);

        drain();
        repeat (END_PAD) @(posedge aclk);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire
